### hw/rtl/mths_pkg.sv
// ----------------------------------------------------------------------------
// mths_pkg
// Shared types and constants for the multi-task heartbeat supervisor.
// ----------------------------------------------------------------------------
package mths_pkg;

    // number of supervised tasks and the width of a task index
    localparam int TASKS = 8;
    localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

    // field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int CNT_W    = 8;
    localparam int STALLED_W = 5;
    localparam int CFG_W    = 8;

    // reset value of the configuration registers and the counter saturation value
    localparam logic [CFG_W-1:0] DEFAULT_LIMIT = 8'd5;
    localparam logic [CNT_W-1:0] CNT_MAX       = '1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_KICK     = 2'd0,
        OP_REGISTER = 2'd1,
        OP_CHECK    = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic {
        CFG_STALL_THRESHOLD = 1'b0,
        CFG_GRACE_CHECKS    = 1'b1
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    // kick / register command into the task table
    typedef struct packed {
        logic             kick;
        logic             enroll;
        logic [IDX_W-1:0] id;
    } tbl_cmd_t;

    // scan write-back into the task table
    typedef struct packed {
        logic             en;
        logic             clear;
        logic [CNT_W-1:0] count;
    } tbl_upd_t;

    // entry seen at the scan index
    typedef struct packed {
        logic             registered;
        logic             kicked;
        logic [CNT_W-1:0] count;
    } tbl_entry_t;

endpackage

### hw/rtl/mths_task_table.sv
// ----------------------------------------------------------------------------
// mths_task_table
// Per-task kick marks, registration marks and stall counters.
// ----------------------------------------------------------------------------
module mths_task_table
    import mths_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_cmd_t         cmd,
    input  logic [IDX_W-1:0] scan_idx,
    input  tbl_upd_t         upd,
    output tbl_entry_t       entry
);

    logic             registered_reg [TASKS];
    logic             kicked_reg     [TASKS];
    logic [CNT_W-1:0] count_reg      [TASKS];

    // read port at the scan index
    assign entry.registered = registered_reg[scan_idx];
    assign entry.kicked     = kicked_reg[scan_idx];
    assign entry.count      = count_reg[scan_idx];

    // marks and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TASKS; t++)
            begin
                registered_reg[t] <= 1'b0;
                kicked_reg[t]     <= 1'b0;
                count_reg[t]      <= '0;
            end
        end
        else
        begin
            if (cmd.kick)
            begin
                kicked_reg[cmd.id] <= 1'b1;
            end
            if (cmd.enroll)
            begin
                registered_reg[cmd.id] <= 1'b1;
            end
            if (upd.en)
            begin
                count_reg[scan_idx] <= upd.count;
                if (upd.clear)
                begin
                    kicked_reg[scan_idx] <= 1'b0;
                end
            end
        end
    end

endmodule

### hw/rtl/multi_task_heartbeat_supervisor.sv
// ----------------------------------------------------------------------------
// multi_task_heartbeat_supervisor
// Heartbeat watchdog over a set of software tasks with stall detection.
// ----------------------------------------------------------------------------
// Kick and register transactions update one task mark (an id beyond the table
// is ignored) and return an all-zero result through the EMIT state. A check
// tick during the startup grace period returns refresh; otherwise the check
// walks the task table one task per cycle through a single saturating
// increment and threshold compare, and a stalled task ends the walk early.
// The input is not ready while a transaction is being processed; a finished
// result sits in an output register, so the next transaction may be accepted
// while it waits to be taken.
module multi_task_heartbeat_supervisor
    import mths_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // operation[1:0], task_id[9:2], zero fill
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata    // refresh[0], stall_found[1],
                                         // stalled_task[6:2], zero fill
);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CFG_W-1:0]   thresh_reg;
    logic [CNT_W-1:0]   grace_reg, grace_next;
    logic               res_refresh_reg, res_refresh_next;
    logic               res_found_reg, res_found_next;
    logic [IDX_W-1:0]   res_task_reg, res_task_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_data_reg, out_data_next;

    op_t                in_op;
    logic [ID_W-1:0]    in_id;
    logic               in_fire;
    logic               id_ok;
    tbl_cmd_t           cmd;
    tbl_upd_t           upd;
    tbl_entry_t         entry;
    logic [CNT_W-1:0]   cnt_inc;
    logic               out_free;
    logic [STALLED_W-1:0] task_ext;

    // input field decode
    assign in_op   = op_t'(s_tdata[1:0]);
    assign in_id   = s_tdata[9:2];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire = s_tvalid && s_tready;
    assign id_ok   = (in_id < ID_W'(TASKS));

    // shared saturating increment
    assign cnt_inc = (entry.count == CNT_MAX) ? CNT_MAX : entry.count + 1'b1;

    assign out_free = !out_valid_reg || m_tready;
    assign task_ext = STALLED_W'(res_task_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // task table
    mths_task_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .scan_idx (idx_reg),
        .upd      (upd),
        .entry    (entry)
    );

    // stall threshold configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= DEFAULT_LIMIT;
        end
        else if (cfg_we && (cfg_idx_t'(cfg_addr) == CFG_STALL_THRESHOLD))
        begin
            thresh_reg <= cfg_wdata;
        end
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            grace_reg       <= DEFAULT_LIMIT;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            grace_reg       <= grace_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_refresh_reg <= res_refresh_next;
        res_found_reg   <= res_found_next;
        res_task_reg    <= res_task_next;
        out_data_reg    <= out_data_next;
    end

    // next state and table control
    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        grace_next       = grace_reg;
        res_refresh_next = res_refresh_reg;
        res_found_next   = res_found_reg;
        res_task_next    = res_task_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        cmd              = '0;
        upd              = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_refresh_next = 1'b0;
                    res_found_next   = 1'b0;
                    res_task_next    = '0;
                    idx_next         = '0;
                    state_next       = ST_EMIT;
                    case (in_op)
                        OP_KICK:
                        begin
                            cmd.kick = id_ok;
                            cmd.id   = in_id[IDX_W-1:0];
                        end
                        OP_REGISTER:
                        begin
                            cmd.enroll = id_ok;
                            cmd.id     = in_id[IDX_W-1:0];
                        end
                        OP_CHECK:
                        begin
                            if (grace_reg != '0)
                            begin
                                grace_next       = grace_reg - 1'b1;
                                res_refresh_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // one task per cycle
                if (entry.registered)
                begin
                    upd.en = 1'b1;
                    if (entry.kicked)
                    begin
                        upd.clear = 1'b1;
                        upd.count = '0;
                    end
                    else
                    begin
                        upd.count = cnt_inc;
                    end
                end
                if (entry.registered && !entry.kicked && (cnt_inc >= thresh_reg))
                begin
                    res_found_next = 1'b1;
                    res_task_next  = idx_reg;
                    state_next     = ST_EMIT;
                end
                else if (idx_reg == IDX_W'(TASKS - 1))
                begin
                    res_refresh_next = 1'b1;
                    state_next       = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, task_ext, res_found_reg, res_refresh_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // grace reload on configuration write
        if (cfg_we && (cfg_idx_t'(cfg_addr) == CFG_GRACE_CHECKS))
        begin
            grace_next = cfg_wdata;
        end
    end

`ifndef NO_ASSERTIONS
    // a result never both feeds and reports a stall
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("refresh and stall_found both set");

    // stalled task index is zero unless a stall was found
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[6:2] == '0))
        else $error("stalled_task set without stall_found");

    // the scan index stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= IDX_W'(TASKS - 1)))
        else $error("scan index out of range");

    // grace count only grows through a configuration write
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> (grace_reg <= $past(grace_reg)))
        else $error("grace count increased without a write");
`endif

endmodule
